FILE: rtl/tri_bary_pkg.sv
// shared constants and types for the triangle barycentric weight block
`default_nettype none
package tri_bary_pkg;

   // coordinate and edge widths
   localparam int COORD_W   = 16;
   localparam int EDGE_W    = COORD_W + 1;
   localparam int PROD_W    = 2 * EDGE_W;
   localparam int DET_W     = PROD_W + 1;
   localparam int MAG_W     = DET_W - 1;

   // reciprocal and divider sizing
   localparam int RECIP_W   = 32;
   localparam int DIV_EXTRA = RECIP_W - 1;
   localparam int LEN_W     = 6;
   localparam int ITER_W    = 7;

   // weight scaling
   localparam int FRAC_BITS = 16;
   localparam int SHIFT_W   = 6;
   localparam int HALF_W    = MAG_W / 2;
   localparam int PART_W    = HALF_W + RECIP_W;
   localparam int SUM_W     = MAG_W + RECIP_W;
   localparam int QUOT_W    = SUM_W - FRAC_BITS + 2;
   localparam int ALPHA_W   = QUOT_W + 1;
   localparam int WEIGHT_W  = 24;

   // configuration register indexes
   localparam int CSR_IDX_W = 3;
   localparam int NUM_REGS  = 6;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_A_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_A_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_B_X = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_B_Y = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_C_X = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_C_Y = 3'd5;

   // per-triangle values handed from setup to the datapath
   typedef struct packed {
      logic [COORD_W-1:0] a_x;
      logic [COORD_W-1:0] a_y;
      logic [EDGE_W-1:0]  ab_x;
      logic [EDGE_W-1:0]  ab_y;
      logic [EDGE_W-1:0]  ac_x;
      logic [EDGE_W-1:0]  ac_y;
      logic [RECIP_W-1:0] inv_det;
      logic [SHIFT_W-1:0] shift;
      logic               neg_det;
      logic               degenerate;
   } setup_type;

endpackage
`default_nettype wire

FILE: rtl/tri_bary_setup.sv
// vertex registers and per-triangle setup: edges, determinant, reciprocal
`default_nettype none
module tri_bary_setup (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [tri_bary_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tri_bary_pkg::COORD_W-1:0]     csr_write_data,
   output logic                                 busy,
   output tri_bary_pkg::setup_type              setup
);
   import tri_bary_pkg::*;

   localparam logic [2:0] ST_EDGE  = 3'd0;
   localparam logic [2:0] ST_MUL   = 3'd1;
   localparam logic [2:0] ST_DET   = 3'd2;
   localparam logic [2:0] ST_LEN   = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;
   localparam logic [2:0] ST_READY = 3'd5;

   logic [COORD_W-1:0]      vertex_ff [NUM_REGS];
   logic [2:0]              state_ff, state_in;
   logic [EDGE_W-1:0]       ab_x_ff, ab_y_ff, ac_x_ff, ac_y_ff;
   logic signed [PROD_W-1:0] p1_ff, p2_ff;
   logic signed [DET_W-1:0] det_in;
   logic [MAG_W-1:0]        mag_ff, mag_in;
   logic                    neg_ff;
   logic [MAG_W-1:0]        scan_ff;
   logic [LEN_W-1:0]        len_ff;
   logic [MAG_W-1:0]        rem_ff;
   logic [MAG_W:0]          rem_try;
   logic [RECIP_W-1:0]      quot_ff;
   logic [RECIP_W-1:0]      inv_ff;
   logic [ITER_W-1:0]       iter_ff;
   logic                    last_iter;
   logic                    cfg_hit;

   // a write to a known register restarts setup
   assign cfg_hit = csr_write_enable && (csr_index < CSR_IDX_W'(NUM_REGS));

   // determinant and its magnitude
   always_comb begin
      det_in = $signed({p1_ff[PROD_W-1], p1_ff}) - $signed({p2_ff[PROD_W-1], p2_ff});
      if (det_in[DET_W-1]) begin
         mag_in = MAG_W'(-det_in);
      end else begin
         mag_in = MAG_W'(det_in);
      end
   end

   // restoring divider step, dividend is all ones
   assign rem_try   = {rem_ff, 1'b1};
   assign last_iter = (iter_ff == (ITER_W'(len_ff) + ITER_W'(DIV_EXTRA - 1)));

   // setup sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_EDGE:  state_in = ST_MUL;
         ST_MUL:   state_in = ST_DET;
         ST_DET:   state_in = ST_LEN;
         ST_LEN: begin
            if (scan_ff == '0) begin
               state_in = (len_ff == '0) ? ST_READY : ST_DIV;
            end
         end
         ST_DIV: begin
            if (last_iter) begin
               state_in = ST_READY;
            end
         end
         ST_READY: state_in = ST_READY;
         default:  state_in = ST_EDGE;
      endcase
      if (cfg_hit) begin
         state_in = ST_EDGE;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EDGE;
         for (int i = 0; i < NUM_REGS; i++) begin
            vertex_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (cfg_hit) begin
            vertex_ff[csr_index] <= csr_write_data;
         end
      end
   end

   // setup datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_EDGE: begin
            ab_x_ff <= {vertex_ff[CSR_VERTEX_B_X][COORD_W-1], vertex_ff[CSR_VERTEX_B_X]}
                     - {vertex_ff[CSR_VERTEX_A_X][COORD_W-1], vertex_ff[CSR_VERTEX_A_X]};
            ab_y_ff <= {vertex_ff[CSR_VERTEX_B_Y][COORD_W-1], vertex_ff[CSR_VERTEX_B_Y]}
                     - {vertex_ff[CSR_VERTEX_A_Y][COORD_W-1], vertex_ff[CSR_VERTEX_A_Y]};
            ac_x_ff <= {vertex_ff[CSR_VERTEX_C_X][COORD_W-1], vertex_ff[CSR_VERTEX_C_X]}
                     - {vertex_ff[CSR_VERTEX_A_X][COORD_W-1], vertex_ff[CSR_VERTEX_A_X]};
            ac_y_ff <= {vertex_ff[CSR_VERTEX_C_Y][COORD_W-1], vertex_ff[CSR_VERTEX_C_Y]}
                     - {vertex_ff[CSR_VERTEX_A_Y][COORD_W-1], vertex_ff[CSR_VERTEX_A_Y]};
         end
         ST_MUL: begin
            p1_ff <= $signed(ab_x_ff) * $signed(ac_y_ff);
            p2_ff <= $signed(ac_x_ff) * $signed(ab_y_ff);
         end
         ST_DET: begin
            mag_ff  <= mag_in;
            scan_ff <= mag_in;
            neg_ff  <= det_in[DET_W-1];
            len_ff  <= '0;
         end
         ST_LEN: begin
            // bit length of the magnitude, one bit a cycle
            if (scan_ff != '0) begin
               scan_ff <= scan_ff >> 1;
               len_ff  <= len_ff + LEN_W'(1);
            end else begin
               rem_ff  <= '0;
               quot_ff <= '0;
               iter_ff <= '0;
               inv_ff  <= '0;
            end
         end
         ST_DIV: begin
            if (rem_try >= {1'b0, mag_ff}) begin
               rem_ff  <= MAG_W'(rem_try - {1'b0, mag_ff});
               quot_ff <= {quot_ff[RECIP_W-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_try[MAG_W-1:0];
               quot_ff <= {quot_ff[RECIP_W-2:0], 1'b0};
            end
            iter_ff <= iter_ff + ITER_W'(1);
            if (last_iter) begin
               inv_ff <= (rem_try >= {1'b0, mag_ff}) ? {quot_ff[RECIP_W-2:0], 1'b1}
                                                     : {quot_ff[RECIP_W-2:0], 1'b0};
            end
         end
         default: begin
         end
      endcase
   end

   assign busy = (state_ff != ST_READY);

   // values for the datapath
   always_comb begin
      setup.a_x        = vertex_ff[CSR_VERTEX_A_X];
      setup.a_y        = vertex_ff[CSR_VERTEX_A_Y];
      setup.ab_x       = ab_x_ff;
      setup.ab_y       = ab_y_ff;
      setup.ac_x       = ac_x_ff;
      setup.ac_y       = ac_y_ff;
      setup.inv_det    = inv_ff;
      setup.shift      = SHIFT_W'(len_ff) + SHIFT_W'(DIV_EXTRA - FRAC_BITS);
      setup.neg_det    = neg_ff;
      setup.degenerate = (len_ff == '0);
   end

endmodule
`default_nettype wire

FILE: rtl/tri_bary_scale.sv
// three-stage scaling of a cross product magnitude by the reciprocal
`default_nettype none
module tri_bary_scale (
   input  logic                                 clock,
   input  logic [tri_bary_pkg::MAG_W-1:0]       mag,
   input  logic                                 neg,
   input  logic [tri_bary_pkg::RECIP_W-1:0]     inv_det,
   input  logic [tri_bary_pkg::SHIFT_W-1:0]     shift,
   output logic signed [tri_bary_pkg::QUOT_W-1:0] quot
);
   import tri_bary_pkg::*;

   logic [PART_W-1:0] lo_ff, hi_ff;
   logic              neg_a_ff, neg_b_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic [SUM_W-1:0]  shifted;
   logic [QUOT_W-1:0] mag_q;
   logic signed [QUOT_W-1:0] quot_ff;

   // partial products on the two halves of the magnitude
   always_ff @(posedge clock) begin
      lo_ff    <= PART_W'(mag[HALF_W-1:0]) * PART_W'(inv_det);
      hi_ff    <= PART_W'(mag[MAG_W-1:HALF_W]) * PART_W'(inv_det);
      neg_a_ff <= neg;
   end

   // recombine and add half an output lsb for rounding
   always_ff @(posedge clock) begin
      sum_ff   <= SUM_W'(lo_ff) + (SUM_W'(hi_ff) << HALF_W)
                + (SUM_W'(1) << (shift - SHIFT_W'(1)));
      neg_b_ff <= neg_a_ff;
   end

   // drop the fraction and restore the sign
   assign shifted = sum_ff >> shift;
   assign mag_q   = shifted[QUOT_W-1:0];

   always_ff @(posedge clock) begin
      quot_ff <= neg_b_ff ? $signed(-mag_q) : $signed(mag_q);
   end

   assign quot = quot_ff;

endmodule
`default_nettype wire

FILE: rtl/tri_bary_pipe.sv
// per-point pipeline: offsets, cross products, scaling, alpha and saturation
`default_nettype none
module tri_bary_pipe (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  logic [tri_bary_pkg::COORD_W-1:0]     point_x,
   input  logic [tri_bary_pkg::COORD_W-1:0]     point_y,
   input  tri_bary_pkg::setup_type              setup,
   output logic                                 out_strobe,
   output logic [tri_bary_pkg::WEIGHT_W-1:0]    weight_a,
   output logic [tri_bary_pkg::WEIGHT_W-1:0]    weight_b,
   output logic [tri_bary_pkg::WEIGHT_W-1:0]    weight_c,
   output logic                                 degenerate
);
   import tri_bary_pkg::*;

   localparam int VALID_DEPTH = 6;

   logic [VALID_DEPTH-1:0]   valid_ff;
   logic [EDGE_W-1:0]        dx_ff, dy_ff;
   logic signed [PROD_W-1:0] mb1_ff, mb2_ff, mc1_ff, mc2_ff;
   logic signed [DET_W-1:0]  nb_in, nc_in;
   logic [MAG_W-1:0]         nb_mag_ff, nc_mag_ff;
   logic                     nb_neg_ff, nc_neg_ff;
   logic signed [QUOT_W-1:0] beta, gamma;
   logic signed [ALPHA_W-1:0] alpha_in;
   logic                     strobe_ff;
   logic [WEIGHT_W-1:0]      wa_ff, wb_ff, wc_ff;
   logic                     degen_ff;

   // clamp a wide signed value to the weight range
   function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [ALPHA_W-1:0] v);
      logic [ALPHA_W-WEIGHT_W:0] top;
      logic [WEIGHT_W-1:0]       res;
      top = v[ALPHA_W-1:WEIGHT_W-1];
      if ((top == '0) || (top == '1)) begin
         res = v[WEIGHT_W-1:0];
      end else if (v[ALPHA_W-1]) begin
         res = {1'b1, {(WEIGHT_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(WEIGHT_W-1){1'b1}}};
      end
      return res;
   endfunction

   // valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         valid_ff  <= {valid_ff[VALID_DEPTH-2:0], in_valid};
         strobe_ff <= valid_ff[VALID_DEPTH-1];
      end
   end

   // stage 1: point relative to vertex a
   always_ff @(posedge clock) begin
      dx_ff <= {point_x[COORD_W-1], point_x} - {setup.a_x[COORD_W-1], setup.a_x};
      dy_ff <= {point_y[COORD_W-1], point_y} - {setup.a_y[COORD_W-1], setup.a_y};
   end

   // stage 2: cross product terms
   always_ff @(posedge clock) begin
      mb1_ff <= $signed(dx_ff) * $signed(setup.ac_y);
      mb2_ff <= $signed(setup.ac_x) * $signed(dy_ff);
      mc1_ff <= $signed(setup.ab_x) * $signed(dy_ff);
      mc2_ff <= $signed(dx_ff) * $signed(setup.ab_y);
   end

   // stage 3: numerators as sign and magnitude
   assign nb_in = $signed({mb1_ff[PROD_W-1], mb1_ff}) - $signed({mb2_ff[PROD_W-1], mb2_ff});
   assign nc_in = $signed({mc1_ff[PROD_W-1], mc1_ff}) - $signed({mc2_ff[PROD_W-1], mc2_ff});

   always_ff @(posedge clock) begin
      nb_mag_ff <= nb_in[DET_W-1] ? MAG_W'(-nb_in) : MAG_W'(nb_in);
      nc_mag_ff <= nc_in[DET_W-1] ? MAG_W'(-nc_in) : MAG_W'(nc_in);
      nb_neg_ff <= nb_in[DET_W-1] ^ setup.neg_det;
      nc_neg_ff <= nc_in[DET_W-1] ^ setup.neg_det;
   end

   // stages 4 to 6: scale by the reciprocal
   tri_bary_scale u_scale_beta (
      .clock   (clock),
      .mag     (nb_mag_ff),
      .neg     (nb_neg_ff),
      .inv_det (setup.inv_det),
      .shift   (setup.shift),
      .quot    (beta)
   );

   tri_bary_scale u_scale_gamma (
      .clock   (clock),
      .mag     (nc_mag_ff),
      .neg     (nc_neg_ff),
      .inv_det (setup.inv_det),
      .shift   (setup.shift),
      .quot    (gamma)
   );

   // stage 7: alpha, saturation, zero-area override
   assign alpha_in = (ALPHA_W'(1) << FRAC_BITS)
                   - $signed({beta[QUOT_W-1], beta})
                   - $signed({gamma[QUOT_W-1], gamma});

   always_ff @(posedge clock) begin
      if (setup.degenerate) begin
         wa_ff <= '0;
         wb_ff <= '0;
         wc_ff <= '0;
      end else begin
         wa_ff <= sat_weight(alpha_in);
         wb_ff <= sat_weight({beta[QUOT_W-1], beta});
         wc_ff <= sat_weight({gamma[QUOT_W-1], gamma});
      end
      degen_ff <= setup.degenerate;
   end

   assign out_strobe = strobe_ff;
   assign weight_a   = wa_ff;
   assign weight_b   = wb_ff;
   assign weight_c   = wc_ff;
   assign degenerate = degen_ff;

endmodule
`default_nettype wire

FILE: rtl/triangle_barycentric_weights.sv
// top level of the triangle barycentric weight block
//
// Usage:
// - vertex registers A, B, C (signed Q12.4) are written through csr_write_enable,
//   csr_index and csr_write_data; indexes above 5 are ignored
// - after reset and after every register write a setup sequencer forms the edge
//   vectors, the determinant, its bit length k (one bit a cycle) and its
//   reciprocal (restoring divider, one quotient bit a cycle); busy is high until
//   setup is done; k is at most 34, and a zero-area triangle skips the divider
// - a point transaction is taken when start is high and busy is low; once setup
//   is done busy stays low and a new point may enter every cycle
// - rsp_strobe marks each result and is high for one cycle, with weights in signed
//   Q8.16, saturated to 24 bits
// - while busy is low the rate is one point per cycle, set by the seven-stage
//   weight pipeline with its 17 by 32 bit partial-product multipliers
// - a zero-area triangle gives zero weights with rsp_degenerate high
// - the receiver cannot stall; every result is taken in its strobe cycle
// - reset is synchronous and clears the vertex registers to zero
`default_nettype none
module triangle_barycentric_weights (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [tri_bary_pkg::COORD_W-1:0]     req_point_x,
   input  logic [tri_bary_pkg::COORD_W-1:0]     req_point_y,
   output logic                                 rsp_strobe,
   output logic [tri_bary_pkg::WEIGHT_W-1:0]    rsp_weight_a,
   output logic [tri_bary_pkg::WEIGHT_W-1:0]    rsp_weight_b,
   output logic [tri_bary_pkg::WEIGHT_W-1:0]    rsp_weight_c,
   output logic                                 rsp_degenerate,
   input  logic                                 csr_write_enable,
   input  logic [tri_bary_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [tri_bary_pkg::COORD_W-1:0]     csr_write_data
);
   import tri_bary_pkg::*;

   setup_type setup;
   logic      setup_busy;
   logic      accept;

   assign busy   = setup_busy;
   assign accept = start && !setup_busy;

   // per-triangle setup
   tri_bary_setup u_setup (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .busy             (setup_busy),
      .setup            (setup)
   );

   // per-point weight pipeline
   tri_bary_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (accept),
      .point_x    (req_point_x),
      .point_y    (req_point_y),
      .setup      (setup),
      .out_strobe (rsp_strobe),
      .weight_a   (rsp_weight_a),
      .weight_b   (rsp_weight_b),
      .weight_c   (rsp_weight_c),
      .degenerate (rsp_degenerate)
   );

endmodule
`default_nettype wire
